### sv/block_read_cache_fifo_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block read cache
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BLOCK_READ_CACHE_FIFO_UNIT_DEFINES_SVH
`define BLOCK_READ_CACHE_FIFO_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BRCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BRCF_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BRCF_ASSERT(label, prop, msg)
`define BRCF_ASSERT_NORST(label, prop, msg)
`endif

`endif

### sv/brcf_pkg.sv
// ----------------------------------------------------------------------------
// Block read cache package
// Result kinds, fill status codes and fixed field widths.
// ----------------------------------------------------------------------------
package brcf_pkg;

  localparam int unsigned ADDR_PORT_W = 32;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned BYTE_W      = 8;

  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_FILL = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_EOF   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FS_PRESENT  = 2'd0,
    FS_PAST_END = 2'd1,
    FS_ERROR    = 2'd2,
    FS_RSVD     = 2'd3
  } fill_status_e;

endpackage

### sv/block_read_cache_fifo_unit.sv
// ----------------------------------------------------------------------------
// Block read cache, fully associative, round-robin replacement
// Splits byte reads at block boundaries, fetches missing blocks by fill beats.
// ----------------------------------------------------------------------------
// Handshake: a read request is taken when start is high and busy is low; busy
// then stays high while the request works. Each block the request touches costs
// a tag search, done by one comparator stepping through the tag RAM; bytes then
// stream one per cycle from the data RAM. On a miss a fill-request result is
// given and busy drops; fill beats are then taken one per cycle with no result
// until the final beat, which resumes the request. An error status, or a
// past-end status on beat zero, ends the fill with an error or EOF result.
// Results (valid strobe) cannot be held off and show for exactly one cycle.
// BLOCK_BYTES must be a power of two.
`include "block_read_cache_fifo_unit_defines.svh"

module block_read_cache_fifo_unit
  import brcf_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = 8,
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned MAX_LEN     = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [ADDR_PORT_W-1:0] address_i,
  input  logic [LEN_W-1:0]       length_i,
  input  logic [BYTE_W-1:0]      fill_byte_i,
  input  logic [1:0]             fill_status_i,
  output logic                   valid_o,
  output logic [1:0]             kind_o,
  output logic [BYTE_W-1:0]      data_o,
  output logic [ADDR_PORT_W-1:0] fill_block_address_o,
  output logic                   last_o
);

  localparam int unsigned IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned OFF_W = $clog2(BLOCK_BYTES);
  localparam int unsigned TAG_W = ADDR_BITS - OFF_W;
  localparam int unsigned DAW   = $clog2(BLOCK_COUNT * BLOCK_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STREAM,
    ST_SEARCH
  } state_e;

  state_e                   state_q, state_d;
  logic [ADDR_BITS-1:0]     cur_addr_q, cur_addr_d;
  logic [LEN_W-1:0]         remain_q, remain_d;
  logic [OFF_W-1:0]         beat_q, beat_d;
  logic                     filling_q, filling_d;
  logic [IDX_W-1:0]         ptr_q, ptr_d;
  logic [BLOCK_COUNT-1:0]   valid_q, valid_d;
  logic [BLOCK_COUNT-1:0]   zero_q, zero_d;
  logic                     hit_ok_q, hit_ok_d;
  logic [IDX_W-1:0]         hit_slot_q, hit_slot_d;
  logic [IDX_W-1:0]         scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]         cmp_idx_q, cmp_idx_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic                     pend_q, pend_d;
  logic                     pend_last_q, pend_last_d;
  logic                     pend_zero_q, pend_zero_d;
  logic                     ctl_vld_q, ctl_vld_d;
  kind_e                    ctl_kind_q, ctl_kind_d;
  logic                     ctl_last_q, ctl_last_d;
  logic [ADDR_PORT_W-1:0]   ctl_addr_q, ctl_addr_d;

  logic [TAG_W-1:0]         cur_tag;
  logic [OFF_W-1:0]         cur_off;
  logic [LEN_W-1:0]         len_clip;
  logic                     tag_we;
  logic [TAG_W-1:0]         tag_rdata;
  logic                     dat_we;
  logic [BYTE_W-1:0]        dat_wdata;
  logic [BYTE_W-1:0]        dat_rdata;
  logic [IDX_W-1:0]         ptr_next;

  assign cur_tag  = cur_addr_q[ADDR_BITS-1:OFF_W];
  assign cur_off  = cur_addr_q[OFF_W-1:0];
  assign len_clip = (length_i > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : length_i;
  assign ptr_next = (ptr_q == IDX_W'(BLOCK_COUNT - 1)) ? '0 : ptr_q + IDX_W'(1);
  assign dat_wdata = (fill_status_i == FS_PRESENT) ? fill_byte_i : '0;

  brcf_ram #(
    .WIDTH (TAG_W),
    .DEPTH (BLOCK_COUNT)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (ptr_q),
    .wdata_i (cur_tag),
    .raddr_i (scan_idx_q),
    .rdata_o (tag_rdata)
  );

  brcf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BLOCK_COUNT * BLOCK_BYTES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (DAW'({ptr_q, beat_q})),
    .wdata_i (dat_wdata),
    .raddr_i (DAW'({hit_slot_q, cur_off})),
    .rdata_o (dat_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cur_addr_d  = cur_addr_q;
    remain_d    = remain_q;
    beat_d      = beat_q;
    filling_d   = filling_q;
    ptr_d       = ptr_q;
    valid_d     = valid_q;
    zero_d      = zero_q;
    hit_ok_d    = hit_ok_q;
    hit_slot_d  = hit_slot_q;
    scan_idx_d  = scan_idx_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    pend_zero_d = 1'b0;
    ctl_vld_d   = 1'b0;
    ctl_kind_d  = KIND_DATA;
    ctl_last_d  = 1'b0;
    ctl_addr_d  = '0;
    tag_we      = 1'b0;
    dat_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_READ) begin
            if (filling_q) begin
              valid_d[ptr_q] = 1'b0;
            end
            filling_d  = 1'b0;
            beat_d     = '0;
            cur_addr_d = ADDR_BITS'(address_i);
            remain_d   = len_clip;
            hit_ok_d   = 1'b0;
            state_d    = ST_STREAM;
          end else if (filling_q) begin
            if (fill_status_i inside {FS_ERROR, FS_RSVD}) begin
              valid_d[ptr_q] = 1'b0;
              filling_d      = 1'b0;
              remain_d       = '0;
              beat_d         = '0;
              ctl_vld_d      = 1'b1;
              ctl_kind_d     = KIND_ERROR;
              ctl_last_d     = 1'b1;
            end else if (fill_status_i == FS_PAST_END && beat_q == '0) begin
              // empty fill: entry reads as all zeros
              valid_d[ptr_q] = 1'b1;
              zero_d[ptr_q]  = 1'b1;
              filling_d      = 1'b0;
              remain_d       = '0;
              ctl_vld_d      = 1'b1;
              ctl_kind_d     = KIND_EOF;
              ctl_last_d     = 1'b1;
            end else begin
              dat_we = 1'b1;
              beat_d = beat_q + OFF_W'(1);
              if (beat_q == OFF_W'(BLOCK_BYTES - 1)) begin
                valid_d[ptr_q] = 1'b1;
                zero_d[ptr_q]  = 1'b0;
                filling_d      = 1'b0;
                beat_d         = '0;
                ptr_d          = ptr_next;
                hit_slot_d     = ptr_q;
                hit_ok_d       = 1'b1;
                state_d        = ST_STREAM;
              end
            end
          end
        end
      end

      ST_STREAM: begin
        if (remain_q == '0) begin
          state_d = ST_IDLE;
        end else if (!hit_ok_q) begin
          scan_idx_d = '0;
          cmp_vld_d  = 1'b0;
          state_d    = ST_SEARCH;
        end else begin
          pend_d      = 1'b1;
          pend_last_d = (remain_q == LEN_W'(1));
          pend_zero_d = zero_q[hit_slot_q];
          remain_d    = remain_q - LEN_W'(1);
          cur_addr_d  = cur_addr_q + ADDR_BITS'(1);
          if (cur_off == OFF_W'(BLOCK_BYTES - 1)) begin
            hit_ok_d = 1'b0;
          end
        end
      end

      ST_SEARCH: begin
        cmp_idx_d  = scan_idx_q;
        cmp_vld_d  = 1'b1;
        scan_idx_d = (scan_idx_q == IDX_W'(BLOCK_COUNT - 1)) ? scan_idx_q
                                                             : scan_idx_q + IDX_W'(1);
        if (cmp_vld_q && valid_q[cmp_idx_q] && tag_rdata == cur_tag) begin
          hit_slot_d = cmp_idx_q;
          hit_ok_d   = 1'b1;
          state_d    = ST_STREAM;
        end else if (cmp_vld_q && cmp_idx_q == IDX_W'(BLOCK_COUNT - 1)) begin
          tag_we         = 1'b1;
          valid_d[ptr_q] = 1'b0;
          filling_d      = 1'b1;
          beat_d         = '0;
          ctl_vld_d      = 1'b1;
          ctl_kind_d     = KIND_FILL;
          ctl_addr_d     = ADDR_PORT_W'({cur_tag, OFF_W'(0)});
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_addr_q  <= '0;
      remain_q    <= '0;
      beat_q      <= '0;
      filling_q   <= 1'b0;
      ptr_q       <= '0;
      valid_q     <= '0;
      zero_q      <= '0;
      hit_ok_q    <= 1'b0;
      hit_slot_q  <= '0;
      scan_idx_q  <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      pend_zero_q <= 1'b0;
      ctl_vld_q   <= 1'b0;
      ctl_kind_q  <= KIND_DATA;
      ctl_last_q  <= 1'b0;
      ctl_addr_q  <= '0;
    end else begin
      state_q     <= state_d;
      cur_addr_q  <= cur_addr_d;
      remain_q    <= remain_d;
      beat_q      <= beat_d;
      filling_q   <= filling_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      zero_q      <= zero_d;
      hit_ok_q    <= hit_ok_d;
      hit_slot_q  <= hit_slot_d;
      scan_idx_q  <= scan_idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      pend_zero_q <= pend_zero_d;
      ctl_vld_q   <= ctl_vld_d;
      ctl_kind_q  <= ctl_kind_d;
      ctl_last_q  <= ctl_last_d;
      ctl_addr_q  <= ctl_addr_d;
    end
  end

  // data transfers come straight off the registered RAM read
  assign busy                 = (state_q != ST_IDLE);
  assign valid_o              = pend_q | ctl_vld_q;
  assign kind_o               = pend_q ? KIND_DATA : ctl_kind_q;
  assign data_o               = (pend_q && !pend_zero_q) ? dat_rdata : '0;
  assign last_o               = pend_q ? pend_last_q : ctl_last_q;
  assign fill_block_address_o = ctl_addr_q;

  `BRCF_ASSERT(a_single_result, !(pend_q && ctl_vld_q), "two results in one cycle")
  `BRCF_ASSERT(a_fill_wait_idle, filling_q |-> state_q == ST_IDLE, "busy while awaiting fill")
  `BRCF_ASSERT(a_fill_req, $rose(filling_q) |-> (ctl_vld_q && ctl_kind_q == KIND_FILL),
    "fill started without fill request")
  `BRCF_ASSERT(a_data_from_stream, pend_q |-> $past(state_q) == ST_STREAM, "stray data transfer")
  `BRCF_ASSERT(a_hit_valid, (hit_ok_q && state_q == ST_STREAM) |-> valid_q[hit_slot_q],
    "streaming from invalid entry")

endmodule

### sv/brcf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
